// ===== rtl/mavef_pkg.sv =====
// Package for the moving average / exponential smoothing filter.
// Holds the sequencer state type, register indexes and fixed field widths.
// No dependencies.
`default_nettype none

package mavef_pkg;

    // Fixed widths of the configuration registers and their port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int WINDOW_W    = 7;
    localparam int ALPHA_W     = 17;
    localparam int FRAC_BITS   = 16;

    localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 17'h10000;
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 17'h08000;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd1;
    localparam logic                MODE_AVERAGE = 1'b0;
    localparam logic                MODE_EXP     = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILTER_MODE = 2'd0,
        CFG_WINDOW_SIZE = 2'd1,
        CFG_SMOOTHING   = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/mavef_div.sv =====
// Bit-serial signed divider: signed dividend by a positive divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// Standalone; no package dependencies.
`default_nettype none

module mavef_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 7
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output logic                         done,
    output logic signed [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DIVISOR_W-1:0]   rem_reg;
    logic [DIVIDEND_W-1:0]  quo_reg;
    logic [DIVISOR_W-1:0]   den_reg;
    logic                   neg_reg;

    logic [DIVISOR_W:0]     shifted;
    logic [DIVISOR_W:0]     trial;
    logic                   fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: work on the magnitude, restore the sign at the end.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[DIVIDEND_W-1];
            quo_reg <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

`default_nettype wire

// ===== rtl/moving_average_or_exponential_filter_core.sv =====
// Moving average / exponential smoothing filter, top level.
// One item is in flight at a time, so the input stalls until the result enters the output register; the
// time per item is set by the one-read-per-cycle history walk over the older samples in the window
// and by the bit-serial divider. Reset is asynchronous and active low; no clearing pass.
`default_nettype none

module moving_average_or_exponential_filter_core
    import mavef_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
)(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input item channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last_in,
    // Result item channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          last_out,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    // Ring addressing and fill count widths.
    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int FC_W  = $clog2(WINDOW_MAX + 1);
    localparam int CW    = (FC_W > WINDOW_W) ? FC_W : WINDOW_W;
    // The window sum holds up to WINDOW_MAX samples.
    localparam int SUM_W = SAMPLE_BITS + AW;
    // Smoothing accumulator is Q(SAMPLE_BITS).16, the difference one bit wider.
    localparam int YW    = SAMPLE_BITS + FRAC_BITS;
    localparam int DW    = YW + 1;
    localparam int BW    = (SAMPLE_BITS + 1 > FRAC_BITS + 1) ? SAMPLE_BITS + 1 : FRAC_BITS + 1;
    localparam int PW    = ALPHA_W + 1 + BW;

    localparam logic [AW-1:0]   SLOT_LAST = AW'(WINDOW_MAX - 1);
    localparam logic [FC_W-1:0] FILL_FULL = FC_W'(WINDOW_MAX);
    localparam logic [AW:0]     RING_LEN  = (AW + 1)'(WINDOW_MAX);
    localparam logic [CW-1:0]   WIN_LIMIT = CW'(WINDOW_MAX);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; unknown
    // indexes are dropped.
    // ------------------------------------------------------------------
    logic                filter_mode_reg;
    logic [WINDOW_W-1:0] window_size_reg;
    logic [ALPHA_W-1:0]  smoothing_factor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg      <= MODE_AVERAGE;
            window_size_reg      <= WINDOW_RESET;
            smoothing_factor_reg <= ALPHA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FILTER_MODE: filter_mode_reg      <= cfg_data[0];
                CFG_WINDOW_SIZE: window_size_reg      <= cfg_data[WINDOW_W-1:0];
                CFG_SMOOTHING:   smoothing_factor_reg <= cfg_data[ALPHA_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and record state.
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [AW-1:0]           slot_reg;
    logic [FC_W-1:0]         fill_reg;
    logic                    started_reg;
    logic signed [YW-1:0]    y_reg;
    logic [CW-1:0]           k_reg;
    logic                    rd_pend_reg;
    logic                    result_valid_reg;

    // Per-item working registers.
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          last_reg;
    logic [CW-1:0]                 terms_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [DW-1:0]          diff_reg;
    logic signed [PW-1:0]          prod_reg;
    logic [ALPHA_W-1:0]            lo_reg;
    logic [SAMPLE_BITS-1:0]        res_reg;
    logic [SAMPLE_BITS-1:0]        filtered_reg;
    logic                          last_out_reg;

    // History ring.
    logic signed [SAMPLE_BITS-1:0] history_mem [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    // Control strobes from the output decode and the divider.
    logic wr_en;
    logic rd_en;
    logic div_start;
    logic div_done;
    logic out_load;

    // ------------------------------------------------------------------
    // Window and term count. A zero window counts as one and a window
    // beyond the ring is clamped to its length.
    // ------------------------------------------------------------------
    logic [CW-1:0]   win_nz;
    logic [CW-1:0]   win_eff;
    logic [FC_W-1:0] fill_next;
    logic [CW-1:0]   fill_ext;
    logic [CW-1:0]   terms_c;

    always_comb
    begin
        win_nz    = (window_size_reg == '0) ? CW'(1) : CW'(window_size_reg);
        win_eff   = (win_nz > WIN_LIMIT) ? WIN_LIMIT : win_nz;
        fill_next = (fill_reg < FILL_FULL) ? FC_W'(fill_reg + 1'b1) : fill_reg;
        fill_ext  = CW'(fill_next);
        terms_c   = (win_eff < fill_ext) ? win_eff : fill_ext;
    end

    // Read address walks backward from the slot just written.
    logic [AW-1:0] k_lo;
    logic [AW-1:0] rd_addr;

    always_comb
    begin
        k_lo = k_reg[AW-1:0];
        if (slot_reg >= k_lo)
            rd_addr = slot_reg - k_lo;
        else
            rd_addr = AW'(({1'b0, slot_reg} + RING_LEN) - {1'b0, k_lo});
    end

    // ------------------------------------------------------------------
    // Output decode.
    // ------------------------------------------------------------------
    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        wr_en      = (state_reg == ST_IDLE) && item_valid;
        rd_en      = (state_reg == ST_SUM) && (k_reg < terms_reg);
        div_start  = (state_reg == ST_SUM) && !rd_en && !rd_pend_reg;
        out_load   = (state_reg == ST_OUT) && (!result_valid_reg || !result_stall);
    end

    // Next-state decode.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (wr_en) state_next = ST_SUM;
            ST_SUM:    if (div_start) state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Divider for the window average.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] div_quotient;

    mavef_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (WINDOW_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (win_eff[WINDOW_W-1:0]),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------
    // Smoothing: alpha*diff/65536 is split into alpha*q + (alpha*r)>>16,
    // with q and r the integer and fraction parts of the difference. One
    // multiplier takes the two products on successive cycles.
    // ------------------------------------------------------------------
    logic [ALPHA_W-1:0]        alpha_eff;
    logic signed [ALPHA_W:0]   mul_a;
    logic signed [SAMPLE_BITS:0] diff_q;
    logic signed [BW-1:0]      mul_b;
    logic signed [PW-1:0]      mul_p;

    always_comb
    begin
        alpha_eff = (smoothing_factor_reg > ALPHA_ONE) ? ALPHA_ONE : smoothing_factor_reg;
        mul_a     = $signed({1'b0, alpha_eff});
        diff_q    = diff_reg[DW-1:FRAC_BITS];
        if (state_reg == ST_MUL_LO)
            mul_b = $signed(BW'(diff_reg[FRAC_BITS-1:0]));
        else
            mul_b = BW'(diff_q);
        mul_p = PW'(mul_a * mul_b);
    end

    logic signed [YW+1:0] y_sum;
    logic signed [YW-1:0] y_new;
    logic [SAMPLE_BITS-1:0] res_c;

    always_comb
    begin
        y_sum = $signed({{2{y_reg[YW-1]}}, y_reg})
              + $signed(prod_reg[YW+1:0])
              + $signed({{(YW + 2 - ALPHA_W){1'b0}}, lo_reg});
        // The first sample of a record passes straight through.
        if (started_reg)
            y_new = y_sum[YW-1:0];
        else
            y_new = {x_reg, {FRAC_BITS{1'b0}}};
        if (filter_mode_reg == MODE_EXP)
            res_c = y_new[YW-1:FRAC_BITS];
        else
            res_c = div_quotient[SAMPLE_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_reg         <= '0;
            fill_reg         <= '0;
            started_reg      <= 1'b0;
            y_reg            <= '0;
            k_reg            <= '0;
            rd_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (wr_en)
                k_reg <= CW'(1);
            else if (rd_en)
                k_reg <= k_reg + 1'b1;
            rd_pend_reg <= rd_en;

            // Record state is committed once per item; a last item clears it.
            if (state_reg == ST_FINISH)
            begin
                if (last_reg)
                begin
                    slot_reg    <= '0;
                    fill_reg    <= '0;
                    started_reg <= 1'b0;
                    y_reg       <= '0;
                end
                else
                begin
                    slot_reg    <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                    fill_reg    <= fill_next;
                    started_reg <= 1'b1;
                    y_reg       <= y_new;
                end
            end

            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_reg     <= sample;
            last_reg  <= last_in;
            terms_reg <= terms_c;
            // The newest sample seeds the sum; older ones are read back.
            sum_reg   <= {{AW{sample[SAMPLE_BITS-1]}}, sample};
            diff_reg  <= $signed({sample[SAMPLE_BITS-1], sample, {FRAC_BITS{1'b0}}})
                       - $signed({y_reg[YW-1], y_reg});
        end
        else if ((state_reg == ST_SUM) && rd_pend_reg)
        begin
            sum_reg <= sum_reg + {{AW{rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};
        end

        if (state_reg == ST_MUL_LO)
            prod_reg <= mul_p;
        if (state_reg == ST_MUL_HI)
        begin
            lo_reg   <= prod_reg[FRAC_BITS+ALPHA_W-1:FRAC_BITS];
            prod_reg <= mul_p;
        end

        if (state_reg == ST_FINISH)
            res_reg <= res_c;

        if (out_load)
        begin
            filtered_reg <= res_reg;
            last_out_reg <= last_reg;
        end
    end

    // History ring: one write on acceptance, one registered read per cycle during the history walk.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            history_mem[slot_reg] <= sample;
        if (rd_en)
            rd_data_reg <= history_mem[rd_addr];
    end

    assign result_valid = result_valid_reg;
    assign filtered     = $signed(filtered_reg);
    assign last_out     = last_out_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond ring length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (k_reg <= terms_reg) && (terms_reg != '0))
        else $error("history walk out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> (y_reg == '0))
        else $error("smoothing accumulator not cleared at record start");
`endif

endmodule

`default_nettype wire
